// ===== rtl/bba_pkg.sv =====
`default_nettype none
package bba_pkg;

  localparam int unsigned NUM_ORDERS = 11;
  localparam int unsigned LINK_DEPTH = 1024;
  localparam int unsigned ADDR_W     = 10;
  localparam int unsigned LINK_W     = 11;
  localparam int unsigned ORD_W      = 4;
  localparam int unsigned SIZE_W     = 11;

  localparam logic [LINK_W-1:0] NIL      = LINK_W'(LINK_DEPTH);
  localparam logic [ORD_W-1:0]  TOP_ORD  = ORD_W'(NUM_ORDERS - 1);
  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(LINK_DEPTH);

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] block_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] alloc_start;
  } rsp_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SRCH_NEXT,
    CMD_NO_SPACE,
    CMD_POP_RD,
    CMD_POP_SPLIT,
    CMD_POP_LAST,
    CMD_PUSH_LO,
    CMD_PUSH_HI,
    CMD_WALK_INIT,
    CMD_WALK_RD,
    CMD_WALK_MATCH,
    CMD_WALK_ADV,
    CMD_PUSH_FREE,
    CMD_EMIT
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_A_SRCH,
    S_A_POPW,
    S_A_PUSHL,
    S_A_PUSHH,
    S_F_LVL,
    S_F_CHK,
    S_F_WALK,
    S_RESP
  } state_e;

  typedef struct packed {
    logic bad;
    logic is_free;
    logic head_nil;
    logic j_top;
    logic j_gt_ord;
    logic walk_end;
    logic match;
    logic out_busy;
  } sts_t;

  // smallest order whose block holds size units; the top order if none does
  function automatic logic [ORD_W-1:0] size_order(input logic [SIZE_W-1:0] size);
    logic [ORD_W-1:0] ord;
    ord = TOP_ORD;
    for (int k = NUM_ORDERS - 1; k >= 0; k--) begin
      if ((SIZE_W+1)'(size) <= ((SIZE_W+1)'(1) << k)) begin
        ord = ORD_W'(k);
      end
    end
    return ord;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bba_ram.sv =====
`default_nettype none
module bba_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/bba_ctrl.sv =====
`default_nettype none
module bba_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire bba_pkg::sts_t sts_i,
  output bba_pkg::cmd_e      cmd_o
);

  bba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = bba_pkg::CMD_NONE;
    in_stall_o = (state_q != bba_pkg::S_IDLE);
    case (state_q)
      bba_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = bba_pkg::CMD_LOAD;
          state_d = bba_pkg::S_DISPATCH;
        end
      end
      bba_pkg::S_DISPATCH: begin
        if (sts_i.bad) begin
          state_d = bba_pkg::S_RESP;
        end else if (sts_i.is_free) begin
          state_d = bba_pkg::S_F_LVL;
        end else begin
          state_d = bba_pkg::S_A_SRCH;
        end
      end
      bba_pkg::S_A_SRCH: begin
        if (!sts_i.head_nil) begin
          cmd_o   = bba_pkg::CMD_POP_RD;
          state_d = bba_pkg::S_A_POPW;
        end else if (sts_i.j_top) begin
          cmd_o   = bba_pkg::CMD_NO_SPACE;
          state_d = bba_pkg::S_RESP;
        end else begin
          cmd_o = bba_pkg::CMD_SRCH_NEXT;
        end
      end
      bba_pkg::S_A_POPW: begin
        if (sts_i.j_gt_ord) begin
          cmd_o   = bba_pkg::CMD_POP_SPLIT;
          state_d = bba_pkg::S_A_PUSHL;
        end else begin
          cmd_o   = bba_pkg::CMD_POP_LAST;
          state_d = bba_pkg::S_RESP;
        end
      end
      bba_pkg::S_A_PUSHL: begin
        cmd_o   = bba_pkg::CMD_PUSH_LO;
        state_d = bba_pkg::S_A_PUSHH;
      end
      bba_pkg::S_A_PUSHH: begin
        cmd_o   = bba_pkg::CMD_PUSH_HI;
        state_d = bba_pkg::S_A_SRCH;
      end
      bba_pkg::S_F_LVL: begin
        if (sts_i.j_top) begin
          cmd_o   = bba_pkg::CMD_PUSH_FREE;
          state_d = bba_pkg::S_RESP;
        end else begin
          cmd_o   = bba_pkg::CMD_WALK_INIT;
          state_d = bba_pkg::S_F_CHK;
        end
      end
      bba_pkg::S_F_CHK: begin
        if (sts_i.walk_end) begin
          cmd_o   = bba_pkg::CMD_PUSH_FREE;
          state_d = bba_pkg::S_RESP;
        end else begin
          cmd_o   = bba_pkg::CMD_WALK_RD;
          state_d = bba_pkg::S_F_WALK;
        end
      end
      bba_pkg::S_F_WALK: begin
        if (sts_i.match) begin
          cmd_o   = bba_pkg::CMD_WALK_MATCH;
          state_d = bba_pkg::S_F_LVL;
        end else begin
          cmd_o   = bba_pkg::CMD_WALK_ADV;
          state_d = bba_pkg::S_F_CHK;
        end
      end
      bba_pkg::S_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o   = bba_pkg::CMD_EMIT;
          state_d = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bba_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/bba_dp.sv =====
`default_nettype none
module bba_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bba_pkg::req_t in_data_i,
  input  wire bba_pkg::cmd_e cmd_i,
  output bba_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output bba_pkg::rsp_t      out_data_o
);

  localparam int unsigned AW = bba_pkg::ADDR_W;
  localparam int unsigned LW = bba_pkg::LINK_W;
  localparam int unsigned OW = bba_pkg::ORD_W;

  logic [LW-1:0] head_q [bba_pkg::NUM_ORDERS];
  logic [LW-1:0] head_d [bba_pkg::NUM_ORDERS];

  logic          type_q, bad_q, rd_zero_q, init0_q, out_valid_q;
  logic [OW-1:0] ord_q, j_q;
  logic [AW-1:0] a_q, start_q;
  logic [LW-1:0] cur_q, prev_q, steps_q;
  logic [1:0]    status_q;
  bba_pkg::rsp_t out_q;

  logic [LW-1:0] head_j, nxt;
  logic [AW-1:0] half, buddy;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [LW-1:0] wdata, rdata;

  assign head_j = head_q[j_q];
  assign half   = AW'(1) << j_q;
  assign buddy  = a_q ^ half;
  // entry 0 holds the end-of-list mark from reset until first written
  assign nxt    = (rd_zero_q && !init0_q) ? bba_pkg::NIL : rdata;

  always_comb begin
    we    = 1'b0;
    waddr = a_q;
    wdata = head_j;
    raddr = head_j[AW-1:0];
    for (int k = 0; k < bba_pkg::NUM_ORDERS; k++) begin
      head_d[k] = head_q[k];
    end
    case (cmd_i)
      bba_pkg::CMD_POP_SPLIT,
      bba_pkg::CMD_POP_LAST: head_d[j_q] = nxt;
      bba_pkg::CMD_PUSH_LO: begin
        we          = 1'b1;
        head_d[j_q] = {1'b0, a_q};
      end
      bba_pkg::CMD_PUSH_HI: begin
        we          = 1'b1;
        waddr       = a_q + half;
        wdata       = {1'b0, a_q};
        head_d[j_q] = {1'b0, a_q + half};
      end
      bba_pkg::CMD_PUSH_FREE: begin
        we          = 1'b1;
        head_d[j_q] = {1'b0, a_q};
      end
      bba_pkg::CMD_WALK_RD: raddr = cur_q[AW-1:0];
      bba_pkg::CMD_WALK_MATCH: begin
        if (prev_q == bba_pkg::NIL) begin
          head_d[j_q] = nxt;
        end else begin
          we    = 1'b1;
          waddr = prev_q[AW-1:0];
          wdata = nxt;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < bba_pkg::NUM_ORDERS; k++) begin
        head_q[k] <= (k == bba_pkg::NUM_ORDERS - 1) ? '0 : bba_pkg::NIL;
      end
      init0_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      for (int k = 0; k < bba_pkg::NUM_ORDERS; k++) begin
        head_q[k] <= head_d[k];
      end
      if (we && waddr == '0) begin
        init0_q <= 1'b1;
      end
      if (cmd_i == bba_pkg::CMD_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      bba_pkg::CMD_LOAD: begin
        type_q   <= in_data_i.req_type;
        bad_q    <= (in_data_i.req_size == '0) || (in_data_i.req_size > bba_pkg::MAX_SIZE);
        ord_q    <= bba_pkg::size_order(in_data_i.req_size);
        j_q      <= bba_pkg::size_order(in_data_i.req_size);
        a_q      <= in_data_i.block_addr &
                    ~AW'((LW'(1) << bba_pkg::size_order(in_data_i.req_size)) - LW'(1));
        status_q <= ((in_data_i.req_size == '0) ||
                     (in_data_i.req_size > bba_pkg::MAX_SIZE)) ?
                    bba_pkg::ST_BAD_SIZE : bba_pkg::ST_DONE;
        start_q  <= '0;
      end
      bba_pkg::CMD_SRCH_NEXT: j_q <= j_q + OW'(1);
      bba_pkg::CMD_NO_SPACE:  status_q <= bba_pkg::ST_NO_SPACE;
      bba_pkg::CMD_POP_RD: begin
        a_q       <= head_j[AW-1:0];
        rd_zero_q <= (head_j[AW-1:0] == '0);
      end
      bba_pkg::CMD_POP_SPLIT: j_q <= j_q - OW'(1);
      bba_pkg::CMD_POP_LAST:  start_q <= a_q;
      bba_pkg::CMD_WALK_INIT: begin
        cur_q   <= head_j;
        prev_q  <= bba_pkg::NIL;
        steps_q <= '0;
      end
      bba_pkg::CMD_WALK_RD: rd_zero_q <= (cur_q[AW-1:0] == '0);
      bba_pkg::CMD_WALK_MATCH: begin
        a_q <= a_q & ~half;
        j_q <= j_q + OW'(1);
      end
      bba_pkg::CMD_WALK_ADV: begin
        prev_q  <= cur_q;
        cur_q   <= nxt;
        steps_q <= steps_q + LW'(1);
      end
      bba_pkg::CMD_EMIT: begin
        out_q.status      <= status_q;
        out_q.alloc_start <= start_q;
      end
      default: begin
      end
    endcase
  end

  bba_ram #(
    .WIDTH(LW),
    .DEPTH(bba_pkg::LINK_DEPTH)
  ) u_link (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    sts_o.bad      = bad_q;
    sts_o.is_free  = type_q;
    sts_o.head_nil = (head_j == bba_pkg::NIL);
    sts_o.j_top    = (j_q == bba_pkg::TOP_ORD);
    sts_o.j_gt_ord = (j_q > ord_q);
    sts_o.walk_end = cur_q[LW-1] || (steps_q > LW'(bba_pkg::LINK_DEPTH));
    sts_o.match    = (cur_q == {1'b0, buddy});
    sts_o.out_busy = out_valid_q && out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/buddy_block_allocator.sv =====
`default_nettype none
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   bba_pkg::req_t (req_type, req_size, block_addr)
// out      output     out_valid_o / out_stall_i bba_pkg::rsp_t (status, alloc_start)
//
// One request at a time; timing is data dependent. A bad size goes straight to the response.
// An allocation searches upward past empty levels, pops a block and splits it level by level,
// pushing both halves onto the lower list; no space ends the search at the top level. A free
// climbs the levels, walking each free list through the registered read of the link memory;
// each walk is bounded. The response waits while an earlier result is still stalled on out.
// No clearing pass after reset. The next request is taken while a result waits on out.
module buddy_block_allocator (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire bba_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output bba_pkg::rsp_t      out_data_o
);

  bba_pkg::cmd_e cmd;
  bba_pkg::sts_t sts;

  bba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bba_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire
